// File: hw/rtl/sfcaf_pkg.sv
// ----------------------------------------------------------------------------
// sfcaf_pkg
// Types and constants for the serial frame CRC and address filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcaf_pkg;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] BROADCAST_ADDR = 8'd0;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STATION_ADDRESS      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_ADDRESS_EN   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_ADDRESS      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LISTEN_ONLY          = 2'd3;

    localparam logic [7:0] RST_STATION_ADDRESS    = 8'd1;
    localparam logic       RST_DEFAULT_ADDRESS_EN = 1'b0;
    localparam logic [7:0] RST_DEFAULT_ADDRESS    = 8'd248;
    localparam logic       RST_LISTEN_ONLY        = 1'b0;

    localparam logic [2:0] VERDICT_BAD_LENGTH    = 3'd0;
    localparam logic [2:0] VERDICT_CRC_ERROR     = 3'd1;
    localparam logic [2:0] VERDICT_NOT_ADDRESSED = 3'd2;
    localparam logic [2:0] VERDICT_OWN           = 3'd3;
    localparam logic [2:0] VERDICT_BROADCAST     = 3'd4;
    localparam logic [2:0] VERDICT_DEFAULT       = 3'd5;

    localparam int FLAG_COMM_ERROR = 0;
    localparam int FLAG_LISTEN     = 1;
    localparam int FLAG_BROADCAST  = 2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [7:0]  frame_address;
        logic [8:0]  frame_length;
        logic [2:0]  event_flags;
        logic        log_event;
        logic [15:0] message_count;
        logic [15:0] crc_error_count;
    } out_item_t;

    typedef struct packed {
        logic [7:0] station_address;
        logic       default_address_enable;
        logic [7:0] default_address;
        logic       listen_only;
    } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/serial_frame_crc_address_filter_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_crc_address_filter_unit
// Receive-side frame check: CRC-16 residue, length and address filtering.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries one frame byte per transaction; end_of_frame marks the
//   last byte. One byte is taken per cycle while in_stall is low; the
//   byte-wide CRC update and the verdict logic sit between the frame state
//   registers and the result register, so the rate is one transaction
//   per cycle. Each end-of-frame transaction yields one out_data
//   transaction from the result register; other bytes yield none.
//   A result register plus one skid register part the two channels: while
//   out_stall holds, input continues until the skid register fills, then
//   in_stall rises (registered) until the receiver takes a result.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
//   next edge and belong to idle periods only.
//   Reset clears the CRC to 0xFFFF, the length, address and both counters,
//   empties the result side and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_crc_address_filter_unit
#(
    parameter int MAX_FRAME_BYTES = 256,
    parameter int MIN_FRAME_BYTES = 4
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire sfcaf_pkg::in_item_t                 in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output sfcaf_pkg::out_item_t                     out_data,
    input  wire logic                                cfg_write,
    input  wire logic [sfcaf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [7:0]                          cfg_data
);

    sfcaf_pkg::cfg_t      cfg_reg, cfg_next;
    logic                 accept;
    logic                 res_valid;
    sfcaf_pkg::out_item_t res;

    logic                 out_valid_reg,  out_valid_next;
    sfcaf_pkg::out_item_t out_data_reg,   out_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    sfcaf_pkg::out_item_t skid_data_reg,  skid_data_next;
    logic                 out_take;

    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_take  = out_valid_reg && !out_stall;

    sfcaf_frame_check
    #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
    )
    u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (in_data),
        .cfg          (cfg_reg),
        .result_valid (res_valid),
        .result       (res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                sfcaf_pkg::CFG_STATION_ADDRESS:    cfg_next.station_address        = cfg_data;
                sfcaf_pkg::CFG_DEFAULT_ADDRESS_EN: cfg_next.default_address_enable = cfg_data[0];
                sfcaf_pkg::CFG_DEFAULT_ADDRESS:    cfg_next.default_address        = cfg_data;
                sfcaf_pkg::CFG_LISTEN_ONLY:        cfg_next.listen_only            = cfg_data[0];
                default:                           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.station_address        <= sfcaf_pkg::RST_STATION_ADDRESS;
            cfg_reg.default_address_enable <= sfcaf_pkg::RST_DEFAULT_ADDRESS_EN;
            cfg_reg.default_address        <= sfcaf_pkg::RST_DEFAULT_ADDRESS;
            cfg_reg.listen_only            <= sfcaf_pkg::RST_LISTEN_ONLY;
            out_valid_reg                  <= 1'b0;
            skid_valid_reg                 <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/sfcaf_crc_byte.sv
// ----------------------------------------------------------------------------
// sfcaf_crc_byte
// One-byte update of the reflected CRC-16, all eight bit steps combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcaf_crc_byte
(
    input  wire logic [15:0] crc,
    input  wire logic [7:0]  data,
    output logic      [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ sfcaf_pkg::CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// File: hw/rtl/sfcaf_frame_check.sv
// ----------------------------------------------------------------------------
// sfcaf_frame_check
// Frame state (CRC, length, address, bus counters) and end-of-frame verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcaf_frame_check
#(
    parameter int MAX_FRAME_BYTES = 256,
    parameter int MIN_FRAME_BYTES = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire sfcaf_pkg::in_item_t  item,
    input  wire sfcaf_pkg::cfg_t      cfg,
    output logic                      result_valid,
    output sfcaf_pkg::out_item_t      result
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME_BYTES);

    logic [15:0]      crc_reg,   crc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       first_reg, first_next;
    logic [15:0]      msg_reg,   msg_next;
    logic [15:0]      err_reg,   err_next;

    logic [15:0]      crc_upd;
    logic [CNT_W-1:0] len;
    logic [7:0]       addr;
    logic             bad_len;
    logic             crc_bad;
    logic [2:0]       verdict;
    logic [2:0]       flags;

    sfcaf_crc_byte u_crc
    (
        .crc     (crc_reg),
        .data    (item.rx_byte),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        len     = (count_reg < CNT_SAT) ? count_reg + CNT_W'(1) : count_reg;
        addr    = (count_reg == '0) ? item.rx_byte : first_reg;
        bad_len = (len < CNT_MIN) || (len > CNT_MAX);
        crc_bad = (crc_upd != 16'h0000);

        flags = 3'b000;
        if (bad_len)
        begin
            verdict = sfcaf_pkg::VERDICT_BAD_LENGTH;
        end
        else
        begin
            flags[sfcaf_pkg::FLAG_LISTEN] = cfg.listen_only;
            priority if (crc_bad)
            begin
                flags[sfcaf_pkg::FLAG_COMM_ERROR] = 1'b1;
                verdict = sfcaf_pkg::VERDICT_CRC_ERROR;
            end
            else if (addr == sfcaf_pkg::BROADCAST_ADDR)
            begin
                flags[sfcaf_pkg::FLAG_BROADCAST] = 1'b1;
                verdict = sfcaf_pkg::VERDICT_BROADCAST;
            end
            else if (addr == cfg.station_address)
            begin
                verdict = sfcaf_pkg::VERDICT_OWN;
            end
            else if (cfg.default_address_enable && addr == cfg.default_address)
            begin
                verdict = sfcaf_pkg::VERDICT_DEFAULT;
            end
            else
            begin
                verdict = sfcaf_pkg::VERDICT_NOT_ADDRESSED;
            end
        end

        msg_next = msg_reg;
        err_next = err_reg;
        if (accept && item.end_of_frame && !bad_len)
        begin
            msg_next = msg_reg + 16'd1;
            if (crc_bad)
            begin
                err_next = err_reg + 16'd1;
            end
        end

        crc_next   = crc_reg;
        count_next = count_reg;
        first_next = first_reg;
        if (accept)
        begin
            if (item.end_of_frame)
            begin
                crc_next   = sfcaf_pkg::CRC_INIT;
                count_next = '0;
                first_next = 8'h00;
            end
            else
            begin
                crc_next   = crc_upd;
                count_next = len;
                first_next = addr;
            end
        end
    end

    always_comb
    begin
        result_valid           = accept && item.end_of_frame;
        result.verdict         = verdict;
        result.frame_address   = addr;
        result.frame_length    = 9'(len);
        result.event_flags     = flags;
        result.log_event       = (flags != 3'b000);
        result.message_count   = msg_next;
        result.crc_error_count = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= sfcaf_pkg::CRC_INIT;
            count_reg <= '0;
            first_reg <= 8'h00;
            msg_reg   <= 16'h0000;
            err_reg   <= 16'h0000;
        end
        else
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            first_reg <= first_next;
            msg_reg   <= msg_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/sfcaf_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcaf_verdict_checker
// Watches the byte, result and register channels of the frame filter, keeps
// its own frame state, predicts each verdict and compares the results.
// ----------------------------------------------------------------------------
module sfcaf_verdict_checker
    import sfcaf_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 256,
    parameter int MIN_FRAME_BYTES = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  in_item_t               in_data,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  out_item_t              out_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    output int                     mismatches,
    output int                     outstanding
);

    cfg_t        regs;
    logic [15:0] frame_crc;
    int unsigned frame_len;
    logic [7:0]  frame_addr;
    logic [15:0] msg_total;
    logic [15:0] crc_err_total;
    out_item_t   pending_verdicts[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          i;
        c = crc ^ {8'h00, b};
        for (i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic rearm_frame();
        frame_crc  = CRC_INIT;
        frame_len  = 0;
        frame_addr = '0;
    endtask

    task automatic predict_frame_byte(input in_item_t item);
        out_item_t v;
        if (frame_len == 0)
            frame_addr = item.rx_byte;
        frame_crc = crc16_step(frame_crc, item.rx_byte);
        if (frame_len < MAX_FRAME_BYTES + 1)
            frame_len++;
        if (item.end_of_frame)
        begin
            v               = '0;
            v.frame_address = frame_addr;
            v.frame_length  = frame_len[8:0];
            if (frame_len < MIN_FRAME_BYTES || frame_len > MAX_FRAME_BYTES)
            begin
                v.verdict = VERDICT_BAD_LENGTH;
            end
            else
            begin
                msg_total++;
                if (regs.listen_only)
                    v.event_flags[FLAG_LISTEN] = 1'b1;
                if (frame_crc != 16'h0000)
                begin
                    crc_err_total++;
                    v.event_flags[FLAG_COMM_ERROR] = 1'b1;
                    v.verdict = VERDICT_CRC_ERROR;
                end
                else if (frame_addr == BROADCAST_ADDR)
                begin
                    v.event_flags[FLAG_BROADCAST] = 1'b1;
                    v.verdict = VERDICT_BROADCAST;
                end
                else if (frame_addr == regs.station_address)
                    v.verdict = VERDICT_OWN;
                else if (regs.default_address_enable && frame_addr == regs.default_address)
                    v.verdict = VERDICT_DEFAULT;
                else
                    v.verdict = VERDICT_NOT_ADDRESSED;
            end
            v.log_event       = |v.event_flags;
            v.message_count   = msg_total;
            v.crc_error_count = crc_err_total;
            pending_verdicts.push_back(v);
            rearm_frame();
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic check_result(input out_item_t act);
        out_item_t exp;
        if (pending_verdicts.size() == 0)
        begin
            $error("result with none pending: verdict %0d, frame_address %0d",
                   act.verdict, act.frame_address);
            mismatches++;
        end
        else
        begin
            exp = pending_verdicts.pop_front();
            check_field("verdict", exp.verdict, act.verdict);
            check_field("frame_address", exp.frame_address, act.frame_address);
            check_field("frame_length", exp.frame_length, act.frame_length);
            check_field("event_flags", exp.event_flags, act.event_flags);
            check_field("log_event", exp.log_event, act.log_event);
            check_field("message_count", exp.message_count, act.message_count);
            check_field("crc_error_count", exp.crc_error_count, act.crc_error_count);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.station_address        = RST_STATION_ADDRESS;
            regs.default_address_enable = RST_DEFAULT_ADDRESS_EN;
            regs.default_address        = RST_DEFAULT_ADDRESS;
            regs.listen_only            = RST_LISTEN_ONLY;
            rearm_frame();
            msg_total     = '0;
            crc_err_total = '0;
            pending_verdicts.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_STATION_ADDRESS:    regs.station_address        = cfg_data;
                    CFG_DEFAULT_ADDRESS_EN: regs.default_address_enable = cfg_data[0];
                    CFG_DEFAULT_ADDRESS:    regs.default_address        = cfg_data;
                    CFG_LISTEN_ONLY:        regs.listen_only            = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                check_result(out_data);
            if (in_valid && !in_stall)
                predict_frame_byte(in_data);
            outstanding = pending_verdicts.size();
        end
    end

endmodule

// File: tb/sv/serial_frame_crc_address_filter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_crc_address_filter_unit_tb
// Sends frames with good, corrupted and missing CRCs, short, typical and
// oversize lengths, to own, broadcast, default and foreign addresses, under
// several register settings and random idling on both channels.
// ----------------------------------------------------------------------------
module serial_frame_crc_address_filter_unit_tb;

    import sfcaf_pkg::*;

    localparam int MAX_BYTES      = 256;
    localparam int MIN_BYTES      = 4;
    localparam int PHASE_ITEMS    = 130;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = '0;

    int         mismatches;
    int         outstanding;
    int         idle_run    = 0;
    int         sent_items  = 0;
    bit         no_idle     = 1'b0;
    logic [7:0] cur_station = RST_STATION_ADDRESS;
    logic [7:0] cur_default = RST_DEFAULT_ADDRESS;

    always #1 clk = ~clk;

    serial_frame_crc_address_filter_unit
    #(
        .MAX_FRAME_BYTES (MAX_BYTES),
        .MIN_FRAME_BYTES (MIN_BYTES)
    )
    dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sfcaf_verdict_checker
    #(
        .MAX_FRAME_BYTES (MAX_BYTES),
        .MIN_FRAME_BYTES (MIN_BYTES)
    )
    verdict_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
        out_stall <= !no_idle && ($urandom_range(0, 99) < 11);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_run <= 0;
        else if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    function automatic logic [15:0] frame_crc(input logic [7:0] fb[$]);
        logic [15:0] c;
        int          i;
        int          j;
        c = CRC_INIT;
        for (i = 0; i < fb.size(); i++)
        begin
            c = c ^ {8'h00, fb[i]};
            for (j = 0; j < 8; j++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eof);
        in_item_t item;
        while (!no_idle && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        item.rx_byte      = b;
        item.end_of_frame = eof;
        in_data  <= item;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sent_items++;
    endtask

    // len >= 3 gets a trailing CRC, low byte first; corrupt flips one bit
    task automatic send_frame(input logic [7:0] addr, input int len, input bit corrupt);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        int          k;
        fb.push_back(addr);
        if (len >= 3)
        begin
            while (fb.size() < len - 2)
                fb.push_back(8'($urandom_range(0, 255)));
            crc = frame_crc(fb);
            fb.push_back(crc[7:0]);
            fb.push_back(crc[15:8]);
        end
        else
        begin
            while (fb.size() < len)
                fb.push_back(8'($urandom_range(0, 255)));
        end
        if (corrupt)
        begin
            k = $urandom_range(0, fb.size() - 1);
            fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (k = 0; k < fb.size(); k++)
            send_byte(fb[k], k == fb.size() - 1);
    endtask

    task automatic send_random_frame();
        int         pick;
        int         len;
        logic [7:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            len = $urandom_range(1, MIN_BYTES - 1);
        else if (pick < 7)
            len = $urandom_range(MAX_BYTES - 2, MAX_BYTES + 4);
        else if (pick < 15)
            len = $urandom_range(MIN_BYTES + 12, 64);
        else
            len = $urandom_range(MIN_BYTES, MIN_BYTES + 12);
        pick = $urandom_range(0, 99);
        if (pick < 30)
            addr = cur_station;
        else if (pick < 45)
            addr = BROADCAST_ADDR;
        else if (pick < 60)
            addr = cur_default;
        else
            addr = 8'($urandom_range(0, 255));
        send_frame(addr, len, $urandom_range(0, 99) < 20);
    endtask

    task automatic run_random_frames(input int n);
        int start;
        start = sent_items;
        while (sent_items - start < n)
            send_random_frame();
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] station, input logic den,
                             input logic [7:0] dflt, input logic listen);
        wait_idle();
        write_reg(CFG_STATION_ADDRESS, station);
        write_reg(CFG_DEFAULT_ADDRESS_EN, {7'd0, den});
        write_reg(CFG_DEFAULT_ADDRESS, dflt);
        write_reg(CFG_LISTEN_ONLY, {7'd0, listen});
        cfg_write <= 1'b0;
        @(posedge clk);
        cur_station = station;
        cur_default = dflt;
    endtask

    initial
    begin
        logic [7:0] station;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(8'd1, 1'b0, 8'd248, 1'b0);
        send_frame(8'hFF, 1, 1'b0);
        send_frame(8'h01, MIN_BYTES - 1, 1'b0);
        send_frame(8'h01, MIN_BYTES, 1'b0);
        send_frame(BROADCAST_ADDR, MIN_BYTES, 1'b0);
        send_frame(8'h5A, MIN_BYTES, 1'b1);

        configure(8'd247, 1'b1, 8'd255, 1'b1);
        send_frame(8'hFF, MIN_BYTES, 1'b0);
        send_frame(8'd247, MIN_BYTES, 1'b1);
        run_random_frames(PHASE_ITEMS);

        // default address of zero: broadcast wins
        configure(8'd1, 1'b1, 8'd0, 1'b0);
        run_random_frames(PHASE_ITEMS);

        // default equal to own address: own wins
        no_idle = 1'b1;
        station = 8'($urandom_range(1, 247));
        configure(station, 1'b1, station, 1'b1);
        run_random_frames(PHASE_ITEMS);
        no_idle = 1'b0;

        configure(8'($urandom_range(1, 247)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        run_random_frames(PHASE_ITEMS);

        configure(8'($urandom_range(1, 247)), 1'b0, 8'($urandom_range(0, 255)), 1'b0);
        run_random_frames(PHASE_ITEMS);

        wait_idle();
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
